### hw/rtl/fault_leaky_bucket_trip_unit_defines.svh
// Assertion macros shared by the fault trip unit.
`ifndef FAULT_LEAKY_BUCKET_TRIP_UNIT_DEFINES_SVH
`define FAULT_LEAKY_BUCKET_TRIP_UNIT_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define FLBT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define FLBT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/flbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package flbt_pkg;

	// Fixed field widths.
	localparam int TYPE_W      = 3;
	localparam int LIMIT_W     = 8;
	localparam int LIMITS_W    = 64;
	localparam int POLICY_W    = 2;
	localparam int COUNT_OUT_W = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	// Extra count added to the limping type once it is over its limit.
	localparam int LIMP_EXTRA = 9;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LIMITS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMP_INDEX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PEC_INDEX  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_CORE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEBUG      = 3'd5;

	// Relay policy codes; the unused code behaves as trip always.
	localparam logic [POLICY_W-1:0] POLICY_TRIP     = 2'd0;
	localparam logic [POLICY_W-1:0] POLICY_BYPASS   = 2'd1;
	localparam logic [POLICY_W-1:0] POLICY_SKIP_PEC = 2'd2;

	typedef struct packed {
		logic [LIMITS_W-1:0] limits;
		logic [TYPE_W-1:0]   limp_index;
		logic [TYPE_W-1:0]   pec_index;
		logic [POLICY_W-1:0] relay_policy;
		logic                stop_core;
		logic                debug_on_trip;
	} cfg_t;

	typedef struct packed {
		logic                   fault_echo;
		logic                   trip_relays;
		logic                   over_limit;
		logic [TYPE_W-1:0]      last_fault;
		logic                   last_fault_valid;
		logic                   core_running;
		logic                   debug_active;
		logic [COUNT_OUT_W-1:0] count_now;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/flbt_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Fault report channel.
interface flbt_req_if import flbt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TYPE_W-1:0] fault_type;
	logic              fault_present;

	modport source (output valid, output fault_type, output fault_present, input ready);
	modport sink   (input valid, input fault_type, input fault_present, output ready);
endinterface

`default_nettype wire

### hw/rtl/flbt_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Trip result channel.
interface flbt_rsp_if import flbt_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   fault_echo;
	logic                   trip_relays;
	logic                   over_limit;
	logic [TYPE_W-1:0]      last_fault;
	logic                   last_fault_valid;
	logic                   core_running;
	logic                   debug_active;
	logic [COUNT_OUT_W-1:0] count_now;

	modport source (output valid, output fault_echo, output trip_relays, output over_limit,
		output last_fault, output last_fault_valid, output core_running,
		output debug_active, output count_now, input ready);
	modport sink (input valid, input fault_echo, input trip_relays, input over_limit,
		input last_fault, input last_fault_valid, input core_running,
		input debug_active, input count_now, output ready);
endinterface

`default_nettype wire

### hw/rtl/fault_leaky_bucket_trip_unit.sv
// Channel   Direction  Word
// req       in         fault_type, fault_present
// rsp       out        echo, trip, over limit, last fault, flags, count_now
// cfg       in         write enable, register index, 64-bit data
//
// Each report passes through the input register, then through the counter
// update into the output register. A new report is accepted every cycle
// unless rsp stalls with both registers full; the counter state commits as a word
// enters the output register, so consecutive reports of one type chain.
// A stall on rsp holds the output register and backs up into req only once
// the input register is also full. Reset clears all counters at once.
`timescale 1ns / 1ps
`default_nettype none
`include "fault_leaky_bucket_trip_unit_defines.svh"

module fault_leaky_bucket_trip_unit import flbt_pkg::*; #(
	parameter int NUM_FAULTS = 8,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	flbt_req_if.sink                   req,
	flbt_rsp_if.source                 rsp
);

	cfg_t              cfg;
	result_t           result;
	result_t           res_s2;
	logic              valid_s1;
	logic [TYPE_W-1:0] type_s1;
	logic              present_s1;
	logic              valid_s2;
	logic              adv;

	flbt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	flbt_tracker #(
		.NUM_FAULTS (NUM_FAULTS),
		.COUNT_BITS (COUNT_BITS)
	) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.commit       (valid_s1 && adv),
		.item_type    (type_s1),
		.item_present (present_s1),
		.result       (result)
	);

	// The output register can take a word when empty or being drained.
	assign adv       = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			type_s1    <= req.fault_type;
			present_s1 <= req.fault_present;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			res_s2 <= result;
		end
	end

	assign rsp.valid            = valid_s2;
	assign rsp.fault_echo       = res_s2.fault_echo;
	assign rsp.trip_relays      = res_s2.trip_relays;
	assign rsp.over_limit       = res_s2.over_limit;
	assign rsp.last_fault       = res_s2.last_fault;
	assign rsp.last_fault_valid = res_s2.last_fault_valid;
	assign rsp.core_running     = res_s2.core_running;
	assign rsp.debug_active     = res_s2.debug_active;
	assign rsp.count_now        = res_s2.count_now;

	// A word leaving the input register always lands in the output register.
	`FLBT_ASSERT(a_word_moves, valid_s1 && adv |=> valid_s2, "input word was lost")
	// A trip is only ever commanded by a report that went over its limit.
	`FLBT_ASSERT(a_trip_over, valid_s2 && res_s2.trip_relays |-> res_s2.over_limit, "trip without over limit")
	// Once over limit, the last fault is marked valid in the same word.
	`FLBT_ASSERT(a_over_valid, valid_s2 && res_s2.over_limit |-> res_s2.last_fault_valid, "over limit without last fault")
	// Both pipeline stages are empty in the cycle after reset is seen low.
	`FLBT_ASSERT_ALWAYS(a_rst_empty, !arst_n |=> !valid_s1 && !valid_s2, "pipeline not empty in reset")

endmodule

`default_nettype wire

### hw/rtl/flbt_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module flbt_cfg_regs import flbt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	// Register writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limits        <= '0;
			cfg_q.limp_index    <= '0;
			cfg_q.pec_index     <= TYPE_W'(1);
			cfg_q.relay_policy  <= POLICY_TRIP;
			cfg_q.stop_core     <= 1'b0;
			cfg_q.debug_on_trip <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LIMITS:     cfg_q.limits        <= cfg_data[LIMITS_W-1:0];
				REG_LIMP_INDEX: cfg_q.limp_index    <= cfg_data[TYPE_W-1:0];
				REG_PEC_INDEX:  cfg_q.pec_index     <= cfg_data[TYPE_W-1:0];
				REG_POLICY:     cfg_q.relay_policy  <= cfg_data[POLICY_W-1:0];
				REG_STOP_CORE:  cfg_q.stop_core     <= cfg_data[0];
				REG_DEBUG:      cfg_q.debug_on_trip <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/flbt_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-type leaky counters, last-fault and mode flags, and the trip decision.
module flbt_tracker import flbt_pkg::*; #(
	parameter int NUM_FAULTS = 8,
	parameter int COUNT_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              commit,
	input  wire logic [TYPE_W-1:0] item_type,
	input  wire logic              item_present,
	output result_t                result
);

	localparam int IDX_W = (NUM_FAULTS > 1) ? $clog2(NUM_FAULTS) : 1;
	localparam logic [TYPE_W:0] NUM_EXT = (TYPE_W + 1)'(NUM_FAULTS);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS:0] EXTRA_EXT = (COUNT_BITS + 1)'(LIMP_EXTRA);

	logic [COUNT_BITS-1:0] count_q [NUM_FAULTS];
	logic [TYPE_W-1:0]     last_fault_q;
	logic                  last_valid_q;
	logic                  core_q;
	logic                  debug_q;

	logic                  in_range;
	logic [IDX_W-1:0]      idx;
	logic [COUNT_BITS-1:0] cur;
	logic [LIMIT_W-1:0]    lim;
	logic [COUNT_BITS:0]   inc1;
	logic [COUNT_BITS-1:0] c1;
	logic [COUNT_BITS:0]   inc9;
	logic [COUNT_BITS-1:0] c9;
	logic [COUNT_BITS-1:0] dec;
	logic [COUNT_BITS-1:0] next_c;
	logic                  over;
	logic                  is_limp;
	logic                  trip_ok;
	logic                  hard_trip;
	logic [TYPE_W-1:0]     last_fault_d;
	logic                  last_valid_d;
	logic                  core_d;
	logic                  debug_d;
	logic [31:0]           count_wide;

	// Counter read and saturating updates.
	always_comb begin
		in_range = {1'b0, item_type} < NUM_EXT;
		idx      = item_type[IDX_W-1:0];
		cur      = count_q[idx];
		lim      = cfg.limits[LIMIT_W*item_type +: LIMIT_W];
		inc1     = {1'b0, cur} + (COUNT_BITS + 1)'(1);
		c1       = inc1[COUNT_BITS] ? COUNT_MAX : inc1[COUNT_BITS-1:0];
		inc9     = {1'b0, c1} + EXTRA_EXT;
		c9       = inc9[COUNT_BITS] ? COUNT_MAX : inc9[COUNT_BITS-1:0];
		dec      = (cur == '0) ? cur : cur - COUNT_BITS'(1);
		is_limp  = item_type == cfg.limp_index;
		over     = in_range && item_present && (c1 > COUNT_BITS'(lim));

		if (!item_present) begin
			next_c = dec;
		end else if (over && is_limp) begin
			next_c = c9;
		end else begin
			next_c = c1;
		end
	end

	// Relay policy and mode flag effects of a trip.
	always_comb begin
		case (cfg.relay_policy)
			POLICY_BYPASS:   trip_ok = 1'b0;
			POLICY_SKIP_PEC: trip_ok = item_type != cfg.pec_index;
			default:         trip_ok = 1'b1;
		endcase
		hard_trip    = over && !is_limp;
		last_fault_d = over ? item_type : last_fault_q;
		last_valid_d = over | last_valid_q;
		core_d       = (hard_trip && cfg.stop_core) ? 1'b0 : core_q;
		debug_d      = (hard_trip && cfg.debug_on_trip) ? 1'b1 : debug_q;
		count_wide   = 32'(next_c);
	end

	// Result word as the state stands after this report.
	always_comb begin
		result.fault_echo       = item_present;
		result.trip_relays      = hard_trip && trip_ok;
		result.over_limit       = over;
		result.last_fault       = last_fault_d;
		result.last_fault_valid = last_valid_d;
		result.core_running     = core_d;
		result.debug_active     = debug_d;
		result.count_now        = in_range ? count_wide[COUNT_OUT_W-1:0] : '0;
	end

	// State commit when the result word moves to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FAULTS; i++) begin
				count_q[i] <= '0;
			end
			last_fault_q <= '0;
			last_valid_q <= 1'b0;
			core_q       <= 1'b1;
			debug_q      <= 1'b0;
		end else if (commit && in_range) begin
			count_q[idx] <= next_c;
			last_fault_q <= last_fault_d;
			last_valid_q <= last_valid_d;
			core_q       <= core_d;
			debug_q      <= debug_d;
		end
	end

endmodule

`default_nettype wire
